/* hdl/rfr_pkg.sv */
// Package for the reply frame receiver: sizes, register indexes,
// configuration and result types, and the frame length clamp.
// No dependencies.
package rfr_pkg;

    localparam int MAX_FRAME = 127;
    localparam int MIN_FRAME = 3;

    localparam logic [7:0] HEADER_CODE_RST  = 8'd193;
    localparam logic [6:0] FRAME_LENGTH_RST = 7'd31;
    localparam logic [9:0] SKIP_LIMIT_RST   = 10'd1023;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LIMIT   = 2'd2;

    typedef struct packed {
        logic [7:0] header_code;
        logic [6:0] frame_length;
        logic [9:0] skip_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [6:0] byte_index;
        logic       frame_last;
        logic       checksum_ok;
        logic       header_matched;
    } t_result;

    // Effective length: register value held to the range MIN_FRAME..MAX_FRAME.
    function automatic logic [6:0] eff_length(input logic [6:0] len);
        logic [6:0] res;
        res = len;
        if (7'(MAX_FRAME) < res) res = 7'(MAX_FRAME);
        if (res < 7'(MIN_FRAME)) res = 7'(MIN_FRAME);
        return res;
    endfunction

endpackage

/* hdl/reply_frame_receiver_top.sv */
// Reply frame receiver top level: input register, frame core, result register.
// Depends on rfr_pkg, rfr_cfg_regs, rfr_frame_core, rfr_out_reg.
//
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------------------
// in       | i_in_valid / o_in_stall    | i_rx_byte
// out      | o_out_valid / i_out_stall  | o_frame_byte, o_byte_index, o_frame_last,
//          |                            | o_checksum_ok, o_header_matched
// cfg      | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// One byte per cycle sustained while the output is not stalled. A byte is
// registered on accept, passes through the frame logic from the input register and
// is loaded into the output register as it moves on; o_out_valid comes up with that
// load, and the result can be taken at an edge where i_out_stall is low.
// Bytes dropped during the header hunt leave the pipeline without waiting on the
// output side. Synchronous active-low reset puts the block in hunt with the
// default registers. A stall on the output backs up into the input register.
module reply_frame_receiver_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [rfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_rx_byte,
    // result items
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_frame_byte,
    output logic [6:0]                      o_byte_index,
    output logic                            o_frame_last,
    output logic                            o_checksum_ok,
    output logic                            o_header_matched
);

    rfr_pkg::t_cfg    cfg;
    rfr_pkg::t_result res;
    rfr_pkg::t_result out_res;
    logic             res_valid;
    logic             out_free;
    logic             fire;

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Held byte moves on when it makes no result or the result register has room
    assign fire       = r_in_valid && (!res_valid || out_free);
    assign o_in_stall = r_in_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    rfr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rfr_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rfr_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && res_valid),
        .i_res   (res),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_frame_byte     = out_res.frame_byte;
    assign o_byte_index     = out_res.byte_index;
    assign o_frame_last     = out_res.frame_last;
    assign o_checksum_ok    = out_res.checksum_ok;
    assign o_header_matched = out_res.header_matched;

endmodule

/* hdl/rfr_cfg_regs.sv */
// Configuration registers of the reply frame receiver.
// Depends on rfr_pkg.
module rfr_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rfr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output rfr_pkg::t_cfg                    o_cfg
);

    rfr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_code  <= rfr_pkg::HEADER_CODE_RST;
            r_cfg.frame_length <= rfr_pkg::FRAME_LENGTH_RST;
            r_cfg.skip_limit   <= rfr_pkg::SKIP_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rfr_pkg::CFG_HEADER_CODE:  r_cfg.header_code  <= i_cfg_data[7:0];
                rfr_pkg::CFG_FRAME_LENGTH: r_cfg.frame_length <= i_cfg_data[6:0];
                rfr_pkg::CFG_SKIP_LIMIT:   r_cfg.skip_limit   <= i_cfg_data;
                default: ;  // unused index, write ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/rfr_frame_core.sv */
// Frame state and per-byte logic: header hunt, position, checksum sum.
// Depends on rfr_pkg.
module rfr_frame_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rfr_pkg::t_cfg     i_cfg,
    input  logic              i_fire,       // byte in input register moves on
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,  // this byte produces a result item
    output rfr_pkg::t_result  o_res
);

    logic        r_hunting;
    logic [9:0]  r_skip_count;
    logic [6:0]  r_position;
    logic [15:0] r_sum;
    logic [7:0]  r_trailer_high;
    logic        r_matched;

    logic        n_hunting;
    logic [9:0]  n_skip_count;
    logic [6:0]  n_position;
    logic [15:0] n_sum;
    logic [7:0]  n_trailer_high;
    logic        n_matched;

    logic [6:0]  len;
    logic [10:0] reads;
    logic        hdr_match;
    logic        forced;
    logic        emit;
    logic [6:0]  pos;
    logic [15:0] sum_cur;
    logic [7:0]  th_cur;
    logic        matched_cur;
    logic        is_last;
    logic        is_trail_hi;

    always_comb begin
        len         = rfr_pkg::eff_length(i_cfg.frame_length);
        reads       = {1'b0, r_skip_count} + 11'd1;
        hdr_match   = (i_byte == i_cfg.header_code);
        forced      = (reads >= {1'b0, i_cfg.skip_limit});
        emit        = !r_hunting || hdr_match || forced;
        // A header restarts the frame from clean state
        pos         = r_hunting ? 7'd0  : r_position;
        sum_cur     = r_hunting ? 16'd0 : r_sum;
        th_cur      = r_hunting ? 8'd0  : r_trailer_high;
        matched_cur = r_hunting ? hdr_match : r_matched;
        is_last     = ({1'b0, pos} + 8'd1) >= {1'b0, len};
        is_trail_hi = ({1'b0, pos} + 8'd2) == {1'b0, len};
    end

    always_comb begin
        n_hunting      = r_hunting;
        n_skip_count   = r_skip_count;
        n_position     = r_position;
        n_sum          = r_sum;
        n_trailer_high = r_trailer_high;
        n_matched      = r_matched;
        if (i_fire) begin
            if (!emit) begin
                n_skip_count = reads[9:0];
            end else begin
                n_matched = matched_cur;
                if (is_last) begin
                    n_hunting      = 1'b1;
                    n_skip_count   = 10'd0;
                    n_position     = 7'd0;
                    n_sum          = 16'd0;
                    n_trailer_high = 8'd0;
                end else begin
                    n_hunting      = 1'b0;
                    n_skip_count   = 10'd0;
                    n_position     = pos + 7'd1;
                    n_sum          = is_trail_hi ? sum_cur : sum_cur + {8'd0, i_byte};
                    n_trailer_high = is_trail_hi ? i_byte : th_cur;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting      <= 1'b1;
            r_skip_count   <= 10'd0;
            r_position     <= 7'd0;
            r_sum          <= 16'd0;
            r_trailer_high <= 8'd0;
            r_matched      <= 1'b0;
        end else begin
            r_hunting      <= n_hunting;
            r_skip_count   <= n_skip_count;
            r_position     <= n_position;
            r_sum          <= n_sum;
            r_trailer_high <= n_trailer_high;
            r_matched      <= n_matched;
        end
    end

    assign o_res_valid          = emit;
    assign o_res.frame_byte     = i_byte;
    assign o_res.byte_index     = pos;
    assign o_res.frame_last     = is_last;
    assign o_res.checksum_ok    = is_last && (sum_cur == {th_cur, i_byte});
    assign o_res.header_matched = matched_cur;

endmodule

/* hdl/rfr_out_reg.sv */
// Result register with valid/stall toward the consumer.
// Depends on rfr_pkg.
module rfr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  rfr_pkg::t_result  i_res,
    input  logic              i_stall,
    output logic              o_free,       // register can take a result this cycle
    output logic              o_valid,
    output rfr_pkg::t_result  o_res
);

    logic             r_valid;
    rfr_pkg::t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* verif/reply_frame_receiver_top_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for reply_frame_receiver_top: header hunt, frame indexing, checksum.
// Depends on rfr_pkg and the reply_frame_receiver_top RTL; needs no other file.
module reply_frame_receiver_top_test;

    // Receiver hold-off used by the backpressure test, in cycles.
    localparam int HOLD_CYCLES    = 48;
    // Cycles with no handshake on either channel before the run is called hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // o_out_valid rises when an accepted byte is loaded into the result register; dropped bytes leave without a result.
    localparam int SETTLE_CYCLES  = 4;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [rfr_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [rfr_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [7:0]                     i_rx_byte;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [7:0]                     o_frame_byte;
    logic [6:0]                     o_byte_index;
    logic                           o_frame_last;
    logic                           o_checksum_ok;
    logic                           o_header_matched;

    reply_frame_receiver_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_frame_byte     (o_frame_byte),
        .o_byte_index     (o_byte_index),
        .o_frame_last     (o_frame_last),
        .o_checksum_ok    (o_checksum_ok),
        .o_header_matched (o_header_matched)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the receiver: register copies and frame tracking state.
    // ------------------------------------------------------------------
    logic [7:0]  reg_header;
    logic [6:0]  reg_length;
    logic [9:0]  reg_skip_limit;

    bit          hunt_on;
    logic [9:0]  hunt_skips;
    logic [6:0]  frame_pos;
    logic [15:0] frame_total;
    logic [7:0]  trailer_hi;
    bit          frame_matched;

    // Frame bytes the block owes us, oldest first.
    rfr_pkg::t_result awaited_frame_bytes[$];

    int          mismatches  = 0;
    int          bytes_sent  = 0;
    int          idle_cycles = 0;

    // Idle controls: percent chance per item/cycle of starting an idle burst.
    int          gap_pct      = 0;
    int          stall_pct    = 0;
    bit          hold_request = 1'b0;

    function automatic int frame_len_now();
        int n;
        n = int'(reg_length);
        if (n > rfr_pkg::MAX_FRAME) n = rfr_pkg::MAX_FRAME;
        if (n < rfr_pkg::MIN_FRAME) n = rfr_pkg::MIN_FRAME;
        return n;
    endfunction

    function automatic void restart_hunt();
        hunt_on     = 1'b1;
        hunt_skips  = '0;
        frame_pos   = '0;
        frame_total = '0;
        trailer_hi  = '0;
    endfunction

    // Works out what one accepted byte produces and queues it.
    function automatic void track_rx_byte(input logic [7:0] b);
        int               len;
        int               reads;
        rfr_pkg::t_result r;
        len = frame_len_now();
        if (hunt_on) begin
            reads = int'(hunt_skips) + 1;
            if (b == reg_header) begin
                // a matching byte wins even if it is also the one that hits the limit
                frame_matched = 1'b1;
            end else if (reads >= int'(reg_skip_limit)) begin
                // limit of zero lands here on the first byte, same as a limit of one
                frame_matched = 1'b0;
            end else begin
                hunt_skips = 10'(reads);
                return;
            end
            restart_hunt();
            hunt_on = 1'b0;
        end
        r.frame_byte     = b;
        r.byte_index     = frame_pos;
        r.frame_last     = 1'b0;
        r.checksum_ok    = 1'b0;
        r.header_matched = frame_matched;
        // ">=" covers a length cut below the current position mid-frame
        if (int'(frame_pos) + 1 >= len) begin
            r.frame_last  = 1'b1;
            r.checksum_ok = (frame_total == {trailer_hi, b});
            restart_hunt();
        end else begin
            if (int'(frame_pos) + 2 == len) trailer_hi = b;
            else frame_total = frame_total + 16'(b);
            frame_pos = frame_pos + 7'd1;
        end
        awaited_frame_bytes.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s at %0t: got 0x%0h, expected 0x%0h", what, $time, got, want);
        mismatches++;
    endtask

    task automatic check_frame_byte();
        rfr_pkg::t_result want;
        if (awaited_frame_bytes.size() == 0) begin
            report_mismatch("frame byte with none awaited", int'(o_frame_byte), 0);
            return;
        end
        want = awaited_frame_bytes.pop_front();
        if (o_frame_byte !== want.frame_byte)
            report_mismatch("frame_byte", int'(o_frame_byte), int'(want.frame_byte));
        if (o_byte_index !== want.byte_index)
            report_mismatch("byte_index", int'(o_byte_index), int'(want.byte_index));
        if (o_frame_last !== want.frame_last)
            report_mismatch("frame_last", int'(o_frame_last), int'(want.frame_last));
        if (o_checksum_ok !== want.checksum_ok)
            report_mismatch("checksum_ok", int'(o_checksum_ok), int'(want.checksum_ok));
        if (o_header_matched !== want.header_matched)
            report_mismatch("header_matched", int'(o_header_matched),
                            int'(want.header_matched));
    endtask

    // Result side: checks what was taken at this edge, then decides the stall
    // for the next one. A pending hold request turns into one long hold-off.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) check_frame_byte();
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 7) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Hang detection: no handshake on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offers one byte, optionally after an idle burst, and returns on the
    // edge that takes it. Valid is left high so back-to-back items flow.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 7);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        track_rx_byte(b);
        bytes_sent++;
    endtask

    // Stop offering and let every owed frame byte and any dropped byte drain.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (awaited_frame_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rfr_pkg::CFG_DATA_W-1:0] data);
        wait_results_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            rfr_pkg::CFG_HEADER_CODE:  reg_header     = data[7:0];
            rfr_pkg::CFG_FRAME_LENGTH: reg_length     = data[6:0];
            rfr_pkg::CFG_SKIP_LIMIT:   reg_skip_limit = data[9:0];
            default: ;
        endcase
    endtask

    // Unused upper data bits get random values; the block must ignore them.
    task automatic set_config(input logic [7:0] hdr, input logic [6:0] len,
                              input logic [9:0] skip);
        write_reg(rfr_pkg::CFG_HEADER_CODE, {2'($urandom), hdr});
        write_reg(rfr_pkg::CFG_FRAME_LENGTH, {3'($urandom), len});
        write_reg(rfr_pkg::CFG_SKIP_LIMIT, skip);
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == reg_header);
        return b;
    endfunction

    // Header, payload, big-endian trailer over everything but the trailer.
    task automatic send_frame(input bit corrupt);
        int          len;
        logic [7:0]  b;
        logic [15:0] total;
        len   = frame_len_now();
        total = 16'(reg_header);
        send_byte(reg_header);
        for (int i = 1; i < len - 2; i++) begin
            b = 8'($urandom);
            total = total + 16'(b);
            send_byte(b);
        end
        if (corrupt) total = total ^ 16'($urandom_range(1, 16'hFFFF));
        send_byte(total[15:8]);
        send_byte(total[7:0]);
    endtask

    // Mostly clean frames; the rest is line noise, cut-off frames and frames with a corrupted trailer.
    task automatic run_traffic(input int budget);
        int stop_at;
        int pick;
        int n;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(noise_byte());
            end else if (pick == 2) begin
                send_byte(reg_header);
                n = $urandom_range(0, frame_len_now());
                repeat (n) send_byte(8'($urandom));
            end else begin
                send_frame(pick == 3);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset registers: header 0xC1, 31-byte frames. Noise is dropped, then a
    // frame starts; it is left open on purpose for the next test.
    task automatic test_reset_defaults();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hC0);
        send_byte(8'hC1);
        send_byte(8'h12);
        send_byte(8'h34);
    endtask

    // Shrinking the length below the open frame's position ends it on the next byte.
    task automatic test_length_cut_mid_frame();
        write_reg(rfr_pkg::CFG_FRAME_LENGTH, 10'd3);
        send_byte(8'h56);
    endtask

    // Header code zero matches a zero byte; length zero is clamped to three.
    task automatic test_zero_header();
        set_config(8'h00, 7'd0, 10'd1023);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
    endtask

    // Skip limit reached: third non-matching byte becomes the header, unmatched.
    task automatic test_forced_header();
        set_config(8'hAA, 7'd2, 10'd3);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        send_byte(8'h00);
        send_byte(8'h03);
    endtask

    // Matching byte arriving exactly at the limit still counts as matched.
    task automatic test_header_at_limit();
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'hAA);
        send_byte(8'h00);
        send_byte(8'hAA);
    endtask

    // Skip limit zero behaves like one: first byte read is forced.
    task automatic test_zero_skip_limit();
        set_config(8'h7E, 7'd1, 10'd0);
        send_byte(8'h55);
        send_byte(8'h00);
        send_byte(8'h55);
    endtask

    // Receiver holds off long enough for the block to back up and stall its input.
    task automatic test_output_hold();
        gap_pct   = 0;
        stall_pct = 0;
        set_config(8'h3C, 7'd20, 10'd16);
        hold_request = 1'b1;
        send_frame(1'b0);
        send_frame(1'b0);
    endtask

    // Sender goes quiet until every owed byte is back, then resumes.
    task automatic test_drain_pause();
        gap_pct   = 20;
        stall_pct = 20;
        send_frame(1'b0);
        wait_results_drained();
        send_frame(1'b1);
        send_byte(noise_byte());
        send_frame(1'b0);
    endtask

    // Phases over the register extremes and random settings, idling varied per phase.
    task automatic test_random_frames();
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 2))
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 15; stall_pct = 15; end
                default: begin gap_pct = 40; stall_pct = 40; end
            endcase
            case (ph)
                0: begin
                    set_config(8'hFF, 7'd127, 10'd1023);
                    run_traffic(60);
                end
                1: begin
                    set_config(8'h00, 7'd0, 10'd0);
                    run_traffic(40);
                end
                2: begin
                    set_config(8'($urandom), 7'd1, 10'd1);
                    run_traffic(40);
                end
                3: begin
                    set_config(8'($urandom), 7'd2, 10'($urandom_range(1, 15)));
                    run_traffic(40);
                end
                default: begin
                    set_config(8'($urandom), 7'($urandom_range(3, 16)),
                               10'($urandom_range(1, 40)));
                    run_traffic(40);
                end
            endcase
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_steady_stream();
        gap_pct   = 0;
        stall_pct = 0;
        set_config(8'($urandom), 7'($urandom_range(3, 10)), 10'($urandom_range(2, 12)));
        run_traffic(100);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_rx_byte   <= '0;
        reg_header     = rfr_pkg::HEADER_CODE_RST;
        reg_length     = rfr_pkg::FRAME_LENGTH_RST;
        reg_skip_limit = rfr_pkg::SKIP_LIMIT_RST;
        frame_matched  = 1'b0;
        restart_hunt();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_length_cut_mid_frame();
        test_zero_header();
        test_forced_header();
        test_header_at_limit();
        test_zero_skip_limit();
        test_output_hold();
        test_drain_pause();
        test_random_frames();
        test_steady_stream();

        wait_results_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
